// ===== hw/rtl/bbc_pkg.sv =====
// bbc_pkg: shared types, operation codes and byte classification for the
// bracket balance checker; used by bbc_front, bbc_stack and the top level
`default_nettype none

package bbc_pkg;

    // default number of stack entries
    localparam int unsigned STACK_DEPTH_DEFAULT = 1024;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;

    // stack operation codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    // bracket kind codes
    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd3;

    // classified byte, as queued between front and back
    typedef struct packed {
        logic [1:0]        op;
        logic [KIND_W-1:0] kind;
        logic              last;
    } bbc_op_t;

    // map one text byte onto a stack operation
    function automatic bbc_op_t classify(input logic [BYTE_W-1:0] b, input logic last);
        bbc_op_t r;
        r.last = last;
        r.op   = OP_NONE;
        r.kind = KIND_ROUND;
        unique case (b)
            8'h28: begin r.op = OP_PUSH; r.kind = KIND_ROUND;  end
            8'h5b: begin r.op = OP_PUSH; r.kind = KIND_SQUARE; end
            8'h3c: begin r.op = OP_PUSH; r.kind = KIND_ANGLE;  end
            8'h7b: begin r.op = OP_PUSH; r.kind = KIND_CURLY;  end
            8'h29: begin r.op = OP_POP;  r.kind = KIND_ROUND;  end
            8'h5d: begin r.op = OP_POP;  r.kind = KIND_SQUARE; end
            8'h3e: begin r.op = OP_POP;  r.kind = KIND_ANGLE;  end
            8'h7d: begin r.op = OP_POP;  r.kind = KIND_CURLY;  end
            default: r.op = OP_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bracket_balance_checker.sv =====
// Bracket balance checker: takes one text byte per cycle while the queue has
// room, back to back; a last beat waits for a free verdict register. A verdict
// goes from the queue through the stack engine step into the verdict register.
// Reset clears depth, error flags, queue and verdict; the stack memory is not
// cleared and needs no clearing pass. Depends on bbc_pkg, bbc_front, bbc_stack.
`default_nettype none

module bracket_balance_checker
#(
    parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  wire logic       s_axis_tlast,   // end_of_text
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] balanced, [1] stack_overflowed, [7:2] zero
);

    logic             op_valid;
    logic             op_ready;
    bbc_pkg::bbc_op_t op;
    logic             balanced;
    logic             overflowed;

    // classification and queue
    bbc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // stack engine
    bbc_stack
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_stack
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .op_valid       (op_valid),
        .op_ready       (op_ready),
        .op             (op),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_balanced   (balanced),
        .out_overflowed (overflowed)
    );

    assign m_axis_tdata = {6'b000000, overflowed, balanced};

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_front.sv =====
// bbc_front: accepts text beats, classifies each byte and holds the
// operations in a two-entry queue for the stack engine; uses bbc_pkg
`default_nettype none

module bbc_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [bbc_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                         in_last,
    output logic                              op_valid,
    input  wire logic                         op_ready,
    output bbc_pkg::bbc_op_t                  op
);

    bbc_pkg::bbc_op_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    // queue handshakes
    assign in_ready = (count_reg != 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign op       = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = op_valid && op_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // classified beat into the queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= bbc_pkg::classify(in_byte, in_last);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_stack.sv =====
// bbc_stack: stack engine that carries out queued push and pop operations
// and registers the verdict of each sequence; uses bbc_pkg
`default_nettype none

module bbc_stack
#(
    parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             op_valid,
    output logic                  op_ready,
    input  wire bbc_pkg::bbc_op_t op,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_balanced,
    output logic                  out_overflowed
);

    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    // stack body; top two entries are mirrored in registers
    logic [bbc_pkg::KIND_W-1:0] mem [STACK_DEPTH];

    logic [DW-1:0]              depth_reg, depth_next;
    logic                       mismatch_reg, mismatch_next;
    logic                       overflow_reg, overflow_next;
    logic [bbc_pkg::KIND_W-1:0] top_reg, top_next;
    logic [bbc_pkg::KIND_W-1:0] second_reg, second_next;
    logic [bbc_pkg::KIND_W-1:0] third_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       balanced_reg, overflowed_reg;
    logic                       take, wr_en, load_out;
    logic [DW-1:0]              depth_step;
    logic [AW-1:0]              rd_addr;

    // a last beat waits until the verdict register is free
    assign op_ready = !op.last || !out_valid_reg || out_ready;
    assign take     = op_valid && op_ready;
    assign load_out = take && op.last;

    // one stack step
    always_comb
    begin
        depth_step    = depth_reg;
        mismatch_next = mismatch_reg;
        overflow_next = overflow_reg;
        top_next      = top_reg;
        second_next   = second_reg;
        wr_en         = 1'b0;
        if (take && !mismatch_reg && !overflow_reg)
        begin
            unique case (op.op)
                bbc_pkg::OP_PUSH:
                begin
                    if (depth_reg == FULL)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        top_next    = op.kind;
                        second_next = top_reg;
                        depth_step  = depth_reg + DW'(1);
                    end
                end
                bbc_pkg::OP_POP:
                begin
                    if (depth_reg == '0 || top_reg != op.kind)
                    begin
                        mismatch_next = 1'b1;
                    end
                    else
                    begin
                        top_next    = second_reg;
                        second_next = third_reg;
                        depth_step  = depth_reg - DW'(1);
                    end
                end
                default:
                begin
                    depth_step = depth_reg;
                end
            endcase
        end
        // sequence state clears after the verdict
        depth_next = load_out ? '0 : depth_step;
        rd_addr    = AW'(depth_next - DW'(3));
    end

    // verdict register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            mismatch_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            mismatch_reg  <= load_out ? 1'b0 : mismatch_next;
            overflow_reg  <= load_out ? 1'b0 : overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // cached top entries and verdict payload
    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        second_reg <= second_next;
        if (load_out)
        begin
            balanced_reg   <= !mismatch_next && !overflow_next && (depth_step == '0);
            overflowed_reg <= overflow_next;
        end
    end

    // stack memory: write at the old depth, prefetch the third entry down
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[depth_reg[AW-1:0]] <= op.kind;
        end
        third_reg <= mem[rd_addr];
    end

    assign out_valid      = out_valid_reg;
    assign out_balanced   = balanced_reg;
    assign out_overflowed = overflowed_reg;

endmodule

`default_nettype wire

// ===== sim/bracket_balance_checker_test.sv =====
// bracket_balance_checker_test: self-checking bench for the bracket balance checker,
// with a built-in nesting predictor, a directed table, then random texts under varied stalls
// depends on bbc_pkg and bracket_balance_checker only
module bracket_balance_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam int unsigned STACK_DEPTH  = STACK_DEPTH_DEFAULT;
    localparam int          RANDOM_BEATS = 450;
    localparam int          PRESSURE_SEQS = 60;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          CYCLE_LIMIT  = 400_000;
    localparam int          MAX_REPORTS  = 10;

    // bracket characters
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5b;
    localparam logic [7:0] CH_RSQUARE = 8'h5d;
    localparam logic [7:0] CH_LANGLE  = 8'h3c;
    localparam logic [7:0] CH_RANGLE  = 8'h3e;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;

    // characters by kind code
    localparam logic [7:0] OPENER_CH [4] = '{CH_LPAREN, CH_LSQUARE, CH_LANGLE, CH_LBRACE};
    localparam logic [7:0] CLOSER_CH [4] = '{CH_RPAREN, CH_RSQUARE, CH_RANGLE, CH_RBRACE};

    // idle percentages per phase: sender light / receiver heavy, swapped, none
    localparam int SEND_IDLE [3] = '{18, 84, 0};
    localparam int RECV_IDLE [3] = '{84, 18, 0};

    typedef logic [7:0] text_t [$];

    typedef struct packed {
        logic              opens;
        logic              closes;
        logic [KIND_W-1:0] kind;
    } bracket_t;

    typedef struct packed {
        logic balanced;
        logic overflowed;
    } verdict_t;

    // one directed row: a byte repeated reps times, tlast on the final copy if set
    typedef struct packed {
        logic [7:0]  text;
        logic [16:0] reps;
        logic        last;
        logic        typed;
        logic        exp_bal;
        logic        exp_ovf;
    } dir_row_t;

    localparam int N_DIRECTED = 24;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // empty pair straight after reset
        '{CH_LPAREN,  17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RPAREN,  17'd1, 1'b1, 1'b1, 1'b1, 1'b0},
        // nul and all-ones are plain text
        '{8'h00,      17'd1, 1'b1, 1'b1, 1'b1, 1'b0},
        '{8'hff,      17'd1, 1'b1, 1'b1, 1'b1, 1'b0},
        // closer with nothing open
        '{CH_RSQUARE, 17'd1, 1'b1, 1'b1, 1'b0, 1'b0},
        // every kind nested and closed in order
        '{CH_LPAREN,  17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_LSQUARE, 17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_LANGLE,  17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_LBRACE,  17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RBRACE,  17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RANGLE,  17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RSQUARE, 17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RPAREN,  17'd1, 1'b1, 1'b0, 1'b0, 1'b0},
        // wrong kind, the matching closer after it is ignored
        '{CH_LANGLE,  17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RBRACE,  17'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RANGLE,  17'd1, 1'b1, 1'b1, 1'b0, 1'b0},
        // left open at the end
        '{CH_LBRACE,  17'd1, 1'b1, 1'b1, 1'b0, 1'b0},
        // stack filled exactly, then emptied
        '{CH_LANGLE,  17'(STACK_DEPTH),     1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RANGLE,  17'(STACK_DEPTH),     1'b1, 1'b1, 1'b1, 1'b0},
        // one opener too many, later closers ignored
        '{CH_LSQUARE, 17'(STACK_DEPTH + 1), 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RSQUARE, 17'd3,                1'b1, 1'b1, 1'b0, 1'b1},
        // overflow on the final beat itself
        '{CH_LBRACE,  17'(STACK_DEPTH + 1), 1'b1, 1'b1, 1'b0, 1'b1},
        // full stack, then a closer of the wrong kind
        '{CH_LPAREN,  17'(STACK_DEPTH),     1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_RBRACE,  17'd1,                1'b1, 1'b1, 1'b0, 1'b0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    // predictor state
    logic [KIND_W-1:0] open_kinds [STACK_DEPTH];
    int unsigned       open_count = 0;
    int unsigned       deepest = 0;
    bit                seq_mismatch = 1'b0;
    bit                seq_overflow = 1'b0;
    verdict_t          verdict_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    bit holding = 1'b0;

    int cycle_count = 0;
    int failures = 0;
    int beats_sent = 0;
    int texts_sent = 0;
    int verdicts_seen = 0;
    int input_stalls = 0;

    bracket_balance_checker #(.STACK_DEPTH(STACK_DEPTH)) dut (.*);

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bracket_t bracket_of(input logic [7:0] b);
        bracket_t br;
        br = '0;
        case (b)
            CH_LPAREN:  begin br.opens  = 1'b1; br.kind = KIND_ROUND;  end
            CH_LSQUARE: begin br.opens  = 1'b1; br.kind = KIND_SQUARE; end
            CH_LANGLE:  begin br.opens  = 1'b1; br.kind = KIND_ANGLE;  end
            CH_LBRACE:  begin br.opens  = 1'b1; br.kind = KIND_CURLY;  end
            CH_RPAREN:  begin br.closes = 1'b1; br.kind = KIND_ROUND;  end
            CH_RSQUARE: begin br.closes = 1'b1; br.kind = KIND_SQUARE; end
            CH_RANGLE:  begin br.closes = 1'b1; br.kind = KIND_ANGLE;  end
            CH_RBRACE:  begin br.closes = 1'b1; br.kind = KIND_CURLY;  end
            default:    br = '0;
        endcase
        return br;
    endfunction

    // nesting predictor: advance by one accepted byte, give a verdict on the final one
    function automatic void track_byte(input logic [7:0] b, input logic last,
                                       output bit done, output verdict_t v);
        bracket_t br;
        br = bracket_of(b);
        done = 1'b0;
        v = '0;
        // errors are sticky, nothing more is looked at until the end
        if (!seq_mismatch && !seq_overflow)
        begin
            if (br.opens)
            begin
                if (open_count >= STACK_DEPTH)
                    seq_overflow = 1'b1;
                else
                begin
                    open_kinds[open_count] = br.kind;
                    open_count++;
                    if (open_count > deepest)
                        deepest = open_count;
                end
            end
            else if (br.closes)
            begin
                if (open_count == 0 || open_kinds[open_count - 1] != br.kind)
                    seq_mismatch = 1'b1;
                else
                    open_count--;
            end
        end
        // verdict, then clear for the next text
        if (last)
        begin
            done = 1'b1;
            v.balanced = !seq_mismatch && !seq_overflow && open_count == 0;
            v.overflowed = seq_overflow;
            open_count = 0;
            seq_mismatch = 1'b0;
            seq_overflow = 1'b0;
        end
    endfunction

    function automatic void note_failure(input string what, input logic [7:0] want,
                                         input logic [7:0] got);
        if (failures < MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        failures++;
    endfunction

    function automatic void check_verdict(input logic [7:0] beat);
        verdict_t want;
        verdicts_seen++;
        if (verdict_q.size() == 0)
            note_failure("verdict with none pending", 8'h00, beat);
        else
        begin
            want = verdict_q.pop_front();
            if (beat[0] !== want.balanced)
                note_failure("balanced", 8'(want.balanced), 8'(beat[0]));
            if (beat[1] !== want.overflowed)
                note_failure("stack_overflowed", 8'(want.overflowed), 8'(beat[1]));
            if (beat[7:2] !== 6'd0)
                note_failure("padding", 8'h00, 8'(beat[7:2]));
        end
    endfunction

    // result side: check accepted beats, stall at random or for the hold-off
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_verdict(m_axis_tdata);
        m_axis_tready <= !holding && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted here once requested
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timed out after %0d cycles, %0d verdicts pending", cycle_count,
                 verdict_q.size());
        $display("bracket_balance_checker_test: FAIL");
        $finish;
    end

    // offer one beat, with random idle cycles ahead of it, and track it once taken
    task automatic send_beat(input logic [7:0] b, input logic last, input bit typed,
                             input verdict_t typed_v);
        bit done;
        verdict_t v;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        track_byte(b, last, done, v);
        beats_sent++;
        if (done)
        begin
            verdict_q.push_back(typed ? typed_v : v);
            texts_sent++;
        end
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i])
            send_beat(t[i], i == t.size() - 1, 1'b0, '0);
    endtask

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        bracket_t br;
        do
        begin
            b = 8'($urandom_range(0, 255));
            br = bracket_of(b);
        end
        while (br.opens || br.closes);
        return b;
    endfunction

    // well-formed text: random nesting of the given number of pairs, with filler
    function automatic text_t build_nested(input int unsigned pairs);
        text_t t;
        logic [KIND_W-1:0] open [$];
        logic [KIND_W-1:0] k;
        int unsigned opened;
        int unsigned r;
        opened = 0;
        while (opened < pairs || open.size() != 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
                t.push_back(filler_byte());
            else if (opened < pairs && (open.size() == 0 || r < 6))
            begin
                k = KIND_W'($urandom_range(0, 3));
                open.push_back(k);
                t.push_back(OPENER_CH[k]);
                opened++;
            end
            else
            begin
                k = open.pop_back();
                t.push_back(CLOSER_CH[k]);
            end
        end
        if (t.size() == 0 || $urandom_range(0, 3) == 0)
            t.push_back(filler_byte());
        return t;
    endfunction

    // broken text: one closer of the wrong kind, a stray bracket, or a lost byte
    function automatic text_t break_text(input text_t t);
        text_t b;
        int unsigned i;
        bracket_t br;
        logic [KIND_W-1:0] k;
        b = t;
        i = $urandom_range(0, b.size() - 1);
        br = bracket_of(b[i]);
        k = KIND_W'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:
            begin
                if (br.closes)
                begin
                    k = br.kind + 2'd1;
                    b[i] = CLOSER_CH[k];
                end
                else
                    b.insert(i, CLOSER_CH[k]);
            end
            1: b.insert(i, CLOSER_CH[k]);
            2: b.insert(i, OPENER_CH[k]);
            default: b.delete(i);
        endcase
        // sometimes more brackets after the fault, which must be ignored
        if ($urandom_range(0, 1) == 1)
            b.push_back(OPENER_CH[KIND_W'($urandom_range(0, 3))]);
        if (b.size() == 0)
            b.push_back(CLOSER_CH[k]);
        return b;
    endfunction

    function automatic text_t noise_text(input int unsigned n);
        text_t t;
        repeat (n) t.push_back(8'($urandom_range(0, 255)));
        return t;
    endfunction

    // stimulus and end of run
    initial
    begin
        dir_row_t row;
        verdict_t typed_v;
        text_t t;
        int phase_start;
        int pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        send_idle_pct = SEND_IDLE[0];
        recv_idle_pct = RECV_IDLE[0];
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = DIRECTED[r];
            typed_v.balanced = row.exp_bal;
            typed_v.overflowed = row.exp_ovf;
            for (int n = 0; n < int'(row.reps); n++)
                send_beat(row.text, row.last && n == int'(row.reps) - 1, row.typed, typed_v);
        end

        // random texts in three idling phases, receiver hold-off before the last
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = SEND_IDLE[p];
            recv_idle_pct = RECV_IDLE[p];
            if (p == 2)
            begin
                hold_req <= 1'b1;
                for (int s = 0; s < PRESSURE_SEQS; s++)
                    send_text(build_nested($urandom_range(0, 1)));
            end
            phase_start = beats_sent;
            while (beats_sent - phase_start < RANDOM_BEATS / 3)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    t = build_nested($urandom_range(0, 5));
                else if (pick < 85)
                    t = break_text(build_nested($urandom_range(1, 5)));
                else
                    t = noise_text($urandom_range(1, 10));
                send_text(t);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding verdicts, then watch for strays
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d text beats in %0d texts, %0d verdicts checked, %0d failures",
                 beats_sent, texts_sent, verdicts_seen, failures);
        $display("deepest nesting %0d of %0d, input held back for %0d cycles",
                 deepest, STACK_DEPTH, input_stalls);
        if (failures == 0 && verdict_q.size() == 0)
            $display("bracket_balance_checker_test: PASS");
        else
            $display("bracket_balance_checker_test: FAIL");
        $finish;
    end

endmodule

// ===== bracket_balance_checker.f =====
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_front.sv
hw/rtl/bbc_stack.sv
hw/rtl/bracket_balance_checker.sv
sim/bracket_balance_checker_test.sv
